FILE: hdl/ctl_pkg.sv
// Shared types and constants of the configuration text lexer.
// Token kinds, the queue record that passes from front to back, queue sizing.
// No dependencies.
package ctl_pkg;

	localparam int CTL_VAL_W = 64;
	localparam int CTL_QDEPTH = 4;
	localparam int CTL_QAW = $clog2(CTL_QDEPTH);
	localparam int CTL_QCW = $clog2(CTL_QDEPTH + 1);

	typedef enum logic [3:0] {
		KIND_ERROR     = 4'd0,
		KIND_NEWLINE   = 4'd1,
		KIND_OPEN      = 4'd2,
		KIND_CLOSE     = 4'd3,
		KIND_COMMA     = 4'd4,
		KIND_SEMI      = 4'd5,
		KIND_INTEGER   = 4'd6,
		KIND_ATOM_BYTE = 4'd7,
		KIND_ATOM_END  = 4'd8,
		KIND_STR_BYTE  = 4'd9,
		KIND_STR_END   = 4'd10
	} kind_t;

	typedef struct packed {
		logic                 two;
		kind_t                kind0;
		logic [CTL_VAL_W-1:0] value0;
		kind_t                kind1;
		logic [CTL_VAL_W-1:0] value1;
	} rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

FILE: hdl/ctl_byte_if.sv
// Valid/ready channel carrying one text byte or the end-of-input mark.
// No dependencies.
interface ctl_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

FILE: hdl/ctl_token_if.sv
// Valid/ready channel carrying one lexer token.
// No dependencies.
interface ctl_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [63:0] token_value;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_value, output last_of_run,
		input ready);
	modport sink (input valid, input token_kind, input token_value, input last_of_run,
		output ready);
endinterface

FILE: hdl/config_text_lexer.sv
// Streaming lexer for configuration text: bytes in, tokens out.
// Depends on ctl_pkg, ctl_byte_if, ctl_token_if, ctl_front, ctl_fifo, ctl_back.
//
// Channels: text carries one byte (or an end-of-input mark) per item; tokens
// carries one token per item, with last_of_run set on the final token caused
// by an input item. A byte causes zero, one or two tokens.
// The front end classifies a byte in the cycle it is accepted and pushes its
// tokens as one record into a four-entry queue; the back end drains records
// from its output register, one token per cycle while tokens.ready is high.
// A byte's record enters the queue when the byte is accepted and is then
// loaded into the output register, where its first token becomes valid.
// Throughput: one byte per cycle while the queue has room; a byte with two
// tokens holds the token port longer and the queue absorbs the difference.
// A stalled token port fills the queue, after which text.ready drops; no
// token is lost or repeated.
// Reset: arst_n clears the lexer to idle between tokens and empties the queue.
module config_text_lexer import ctl_pkg::*; #(
	parameter int MAX_ATOM = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	ctl_byte_if.sink    text,
	ctl_token_if.source tokens
);

	q_stat_t q_stat;
	logic    q_push, q_pop;
	rec_t    q_rec, q_head;

	ctl_front #(
		.MAX_ATOM(MAX_ATOM),
		.VALUE_BITS(VALUE_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.text(text),
		.q_stat(q_stat),
		.q_push(q_push),
		.q_rec(q_rec)
	);

	ctl_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_rec(q_rec),
		.pop(q_pop),
		.head(q_head),
		.stat(q_stat)
	);

	ctl_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(q_head),
		.q_stat(q_stat),
		.pop(q_pop),
		.tokens(tokens)
	);

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_stat.full))
		else $error("queue push while full");

	a_valueless_kinds_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.token_kind != KIND_INTEGER
			&& tokens.token_kind != KIND_ATOM_BYTE
			&& tokens.token_kind != KIND_STR_BYTE) |-> tokens.token_value == '0)
		else $error("nonzero value on a token kind without value");

	a_byte_kinds_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && (tokens.token_kind == KIND_ATOM_BYTE
			|| tokens.token_kind == KIND_STR_BYTE)) |-> tokens.token_value[63:8] == '0)
		else $error("byte token wider than eight bits");

	a_second_token_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(tokens.valid && tokens.ready && !tokens.last_of_run) |=> tokens.valid)
		else $error("second token of an item went missing");

endmodule

FILE: hdl/ctl_front.sv
// Lexer front end: accepts bytes, runs the lexer state machine, and pushes
// the zero to two tokens of each item into the queue as one record.
// Depends on ctl_pkg and ctl_byte_if.
module ctl_front import ctl_pkg::*; #(
	parameter int MAX_ATOM = 64,
	parameter int VALUE_BITS = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	ctl_byte_if.sink      text,
	input  q_stat_t       q_stat,
	output logic          q_push,
	output rec_t          q_rec
);

	localparam int AW = $clog2(MAX_ATOM + 1);

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_FF    = 8'h0C;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_LP    = 8'h28;
	localparam logic [7:0] CH_RP    = 8'h29;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_7     = 8'h37;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_QM    = 8'h3F;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_UX    = 8'h58;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LB    = 8'h62;
	localparam logic [7:0] CH_LF_   = 8'h66;
	localparam logic [7:0] CH_LN    = 8'h6E;
	localparam logic [7:0] CH_LR    = 8'h72;
	localparam logic [7:0] CH_LT    = 8'h74;
	localparam logic [7:0] CH_LV    = 8'h76;
	localparam logic [7:0] CH_LX    = 8'h78;

	typedef enum logic [3:0] {
		MODE_IDLE, MODE_COMMENT, MODE_ZERO, MODE_DEC, MODE_OCT, MODE_HEX,
		MODE_ATOM, MODE_STRING, MODE_ESC, MODE_ESC_HEX, MODE_ESC_OCT
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic       emit;
		kind_t      kind;
		logic [7:0] val;
		logic       load_num;
		logic       set_quote;
		logic       quote;
		logic       start_atom;
	} idle_act_t;

	typedef struct packed {
		mode_t      mode;
		logic       emit;
		kind_t      kind;
		logic [7:0] val;
	} str_act_t;

	function automatic logic is_skip(logic [7:0] c);
		return c == CH_NUL || c == CH_SP || c == CH_TAB || c == CH_CR || c == CH_VT
			|| c == CH_FF;
	endfunction

	function automatic logic is_oct(logic [7:0] c);
		return c inside {[CH_0:CH_7]};
	endfunction

	function automatic logic is_dec(logic [7:0] c);
		return c inside {[CH_0:CH_9]};
	endfunction

	function automatic logic [4:0] hex_val(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c inside {[CH_0:CH_9]}) r = {1'b1, 4'(c - CH_0)};
		else if (c inside {[CH_LA:CH_LF_]}) r = {1'b1, 4'(c - CH_LA + 8'd10)};
		else if (c inside {[CH_UA:CH_UF]}) r = {1'b1, 4'(c - CH_UA + 8'd10)};
		return r;
	endfunction

	function automatic logic [8:0] named_esc(logic [7:0] c);
		logic [8:0] r;
		r = '0;
		case (c)
			CH_SQ, CH_DQ, CH_QM, CH_BSL: r = {1'b1, c};
			CH_LA:  r = {1'b1, 8'd7};
			CH_LB:  r = {1'b1, 8'd8};
			CH_LF_: r = {1'b1, 8'd12};
			CH_LN:  r = {1'b1, 8'd10};
			CH_LR:  r = {1'b1, 8'd13};
			CH_LT:  r = {1'b1, 8'd9};
			CH_LV:  r = {1'b1, 8'd11};
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic ends_atom(logic [7:0] c);
		return is_skip(c) || c == CH_LF || c == CH_DOT || c == CH_LP || c == CH_RP
			|| c == CH_SEMI || c == CH_COMMA;
	endfunction

	function automatic idle_act_t idle_fn(logic [7:0] c);
		idle_act_t a;
		a = '{mode: MODE_IDLE, emit: 1'b0, kind: KIND_ERROR, val: '0, load_num: 1'b0,
			set_quote: 1'b0, quote: 1'b0, start_atom: 1'b0};
		if (!is_skip(c)) begin
			case (c)
				CH_LF: begin
					a.emit = 1'b1;
					a.kind = KIND_NEWLINE;
				end
				CH_HASH: a.mode = MODE_COMMENT;
				CH_LP: begin
					a.emit = 1'b1;
					a.kind = KIND_OPEN;
				end
				CH_RP: begin
					a.emit = 1'b1;
					a.kind = KIND_CLOSE;
				end
				CH_COMMA: begin
					a.emit = 1'b1;
					a.kind = KIND_COMMA;
				end
				CH_SEMI: begin
					a.emit = 1'b1;
					a.kind = KIND_SEMI;
				end
				CH_DOT: begin
					a.emit = 1'b1;
					a.kind = KIND_ERROR;
				end
				default: begin
					if (is_dec(c)) begin
						a.mode = (c == CH_0) ? MODE_ZERO : MODE_DEC;
						a.load_num = 1'b1;
					end else if (c == CH_DQ || c == CH_SQ) begin
						a.mode = MODE_STRING;
						a.set_quote = 1'b1;
						a.quote = (c == CH_SQ);
					end else begin
						a.mode = MODE_ATOM;
						a.start_atom = 1'b1;
						a.emit = 1'b1;
						a.kind = KIND_ATOM_BYTE;
						a.val = c;
					end
				end
			endcase
		end
		return a;
	endfunction

	function automatic str_act_t str_fn(logic [7:0] c, logic single);
		str_act_t a;
		logic [7:0] qc;
		qc = single ? CH_SQ : CH_DQ;
		a = '{mode: MODE_STRING, emit: 1'b0, kind: KIND_STR_BYTE, val: '0};
		if (c == CH_BSL) begin
			a.mode = MODE_ESC;
		end else if (c == qc) begin
			a.mode = MODE_IDLE;
			a.emit = 1'b1;
			a.kind = KIND_STR_END;
		end else begin
			a.emit = 1'b1;
			a.val = c;
		end
		return a;
	endfunction

	mode_t                 mode_q, mode_d;
	logic                  quote_q, quote_d;
	logic [VALUE_BITS-1:0] num_q, num_d;
	logic [7:0]            esc_q, esc_d;
	logic [1:0]            cnt_q, cnt_d;
	logic [AW-1:0]         atom_q, atom_d;

	idle_act_t             ia;
	str_act_t              sa;
	logic [7:0]            c;
	logic [4:0]            hv;
	logic [8:0]            ne;
	logic [7:0]            esc_hex, esc_oct;
	logic                  p_en, s_en, use_idle, use_str;
	kind_t                 p_kind, s_kind;
	logic [CTL_VAL_W-1:0]  p_val, s_val;
	logic                  fire;

	assign c = text.in_byte;
	assign ia = idle_fn(c);
	assign sa = str_fn(c, quote_q);
	assign hv = hex_val(c);
	assign ne = named_esc(c);
	assign esc_hex = {esc_q[3:0], hv[3:0]};
	assign esc_oct = {esc_q[4:0], c[2:0]};

	assign text.ready = !q_stat.full;
	assign fire = text.valid && text.ready;

	always_comb begin
		mode_d = mode_q;
		quote_d = quote_q;
		num_d = num_q;
		esc_d = esc_q;
		cnt_d = cnt_q;
		atom_d = atom_q;
		p_en = 1'b0;
		p_kind = KIND_ERROR;
		p_val = '0;
		use_idle = 1'b0;
		use_str = 1'b0;
		if (text.end_of_input) begin
			case (mode_q)
				MODE_ZERO, MODE_DEC, MODE_OCT, MODE_HEX: begin
					p_en = 1'b1;
					p_kind = KIND_INTEGER;
					p_val = CTL_VAL_W'(num_q);
				end
				MODE_ATOM: begin
					p_en = 1'b1;
					p_kind = KIND_ATOM_END;
				end
				MODE_STRING, MODE_ESC, MODE_ESC_HEX, MODE_ESC_OCT: begin
					p_en = 1'b1;
					p_kind = KIND_ERROR;
				end
				default: p_en = 1'b0;
			endcase
			mode_d = MODE_IDLE;
			quote_d = 1'b0;
			num_d = '0;
			cnt_d = '0;
			atom_d = '0;
		end else begin
			case (mode_q)
				MODE_COMMENT: if (c == CH_LF) mode_d = MODE_IDLE;
				MODE_ZERO: begin
					if (c == CH_LX || c == CH_UX) begin
						mode_d = MODE_HEX;
						num_d = '0;
					end else if (is_oct(c)) begin
						mode_d = MODE_OCT;
						num_d = VALUE_BITS'(c[2:0]);
					end else begin
						p_en = 1'b1;
						p_kind = KIND_INTEGER;
						p_val = CTL_VAL_W'(num_q);
						use_idle = 1'b1;
					end
				end
				MODE_DEC: begin
					if (is_dec(c)) begin
						num_d = (num_q << 3) + (num_q << 1) + VALUE_BITS'(c[3:0]);
					end else begin
						p_en = 1'b1;
						p_kind = KIND_INTEGER;
						p_val = CTL_VAL_W'(num_q);
						use_idle = 1'b1;
					end
				end
				MODE_OCT: begin
					if (is_oct(c)) begin
						num_d = (num_q << 3) + VALUE_BITS'(c[2:0]);
					end else begin
						p_en = 1'b1;
						p_kind = KIND_INTEGER;
						p_val = CTL_VAL_W'(num_q);
						use_idle = 1'b1;
					end
				end
				MODE_HEX: begin
					if (hv[4]) begin
						num_d = (num_q << 4) + VALUE_BITS'(hv[3:0]);
					end else begin
						p_en = 1'b1;
						p_kind = KIND_INTEGER;
						p_val = CTL_VAL_W'(num_q);
						use_idle = 1'b1;
					end
				end
				MODE_ATOM: begin
					if (!ends_atom(c)) begin
						if (atom_q < AW'(MAX_ATOM)) begin
							p_en = 1'b1;
							p_kind = KIND_ATOM_BYTE;
							p_val = CTL_VAL_W'(c);
							atom_d = atom_q + AW'(1);
						end
					end else begin
						p_en = 1'b1;
						p_kind = KIND_ATOM_END;
						atom_d = '0;
						use_idle = 1'b1;
					end
				end
				MODE_STRING: use_str = 1'b1;
				MODE_ESC: begin
					if (c == CH_LX || c == CH_UX) begin
						mode_d = MODE_ESC_HEX;
						esc_d = '0;
						cnt_d = '0;
					end else if (is_oct(c)) begin
						mode_d = MODE_ESC_OCT;
						esc_d = {5'd0, c[2:0]};
						cnt_d = 2'd1;
					end else if (ne[8]) begin
						p_en = 1'b1;
						p_kind = KIND_STR_BYTE;
						p_val = CTL_VAL_W'(ne[7:0]);
						mode_d = MODE_STRING;
					end else begin
						p_en = 1'b1;
						p_kind = KIND_ERROR;
						mode_d = MODE_IDLE;
					end
				end
				MODE_ESC_HEX: begin
					if (hv[4]) begin
						if (cnt_q != 2'd0) begin
							p_en = 1'b1;
							p_kind = KIND_STR_BYTE;
							p_val = CTL_VAL_W'(esc_hex);
							mode_d = MODE_STRING;
							cnt_d = '0;
						end else begin
							esc_d = esc_hex;
							cnt_d = 2'd1;
						end
					end else if (cnt_q == 2'd0) begin
						p_en = 1'b1;
						p_kind = KIND_ERROR;
						use_idle = 1'b1;
					end else begin
						p_en = 1'b1;
						p_kind = KIND_STR_BYTE;
						p_val = CTL_VAL_W'(esc_q);
						cnt_d = '0;
						use_str = 1'b1;
					end
				end
				MODE_ESC_OCT: begin
					if (is_oct(c)) begin
						if (cnt_q == 2'd2) begin
							p_en = 1'b1;
							p_kind = KIND_STR_BYTE;
							p_val = CTL_VAL_W'(esc_oct);
							mode_d = MODE_STRING;
							cnt_d = '0;
						end else begin
							esc_d = esc_oct;
							cnt_d = cnt_q + 2'd1;
						end
					end else begin
						p_en = 1'b1;
						p_kind = KIND_STR_BYTE;
						p_val = CTL_VAL_W'(esc_q);
						cnt_d = '0;
						use_str = 1'b1;
					end
				end
				default: use_idle = 1'b1;
			endcase
			if (use_idle) begin
				mode_d = ia.mode;
				cnt_d = '0;
				if (ia.load_num) num_d = VALUE_BITS'(c[3:0]);
				if (ia.set_quote) quote_d = ia.quote;
				if (ia.start_atom) atom_d = AW'(1);
			end
			if (use_str) mode_d = sa.mode;
		end
	end

	always_comb begin
		s_en = 1'b0;
		s_kind = KIND_ERROR;
		s_val = '0;
		if (use_idle) begin
			s_en = ia.emit;
			s_kind = ia.kind;
			s_val = CTL_VAL_W'(ia.val);
		end else if (use_str) begin
			s_en = sa.emit;
			s_kind = sa.kind;
			s_val = CTL_VAL_W'(sa.val);
		end
		q_rec.two = p_en && s_en;
		q_rec.kind1 = s_kind;
		q_rec.value1 = s_val;
		if (p_en) begin
			q_rec.kind0 = p_kind;
			q_rec.value0 = p_val;
		end else begin
			q_rec.kind0 = s_kind;
			q_rec.value0 = s_val;
		end
		q_push = fire && (p_en || s_en);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			quote_q <= 1'b0;
			num_q <= '0;
			esc_q <= '0;
			cnt_q <= '0;
			atom_q <= '0;
		end else if (fire) begin
			mode_q <= mode_d;
			quote_q <= quote_d;
			num_q <= num_d;
			esc_q <= esc_d;
			cnt_q <= cnt_d;
			atom_q <= atom_d;
		end
	end

endmodule

FILE: hdl/ctl_fifo.sv
// Short record queue between the lexer front end and the token back end.
// Depends on ctl_pkg.
module ctl_fifo import ctl_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  rec_t    push_rec,
	input  logic    pop,
	output rec_t    head,
	output q_stat_t stat
);

	rec_t               mem [CTL_QDEPTH];
	logic [CTL_QAW-1:0] wr_q, rd_q;
	logic [CTL_QCW-1:0] cnt_q;
	logic               do_push, do_pop;

	assign stat.full = (cnt_q == CTL_QCW'(CTL_QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push = push && !stat.full;
	assign do_pop = pop && !stat.empty;
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem[wr_q] <= push_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + CTL_QAW'(1);
			if (do_pop) rd_q <= rd_q + CTL_QAW'(1);
			if (do_push && !do_pop) cnt_q <= cnt_q + CTL_QCW'(1);
			else if (do_pop && !do_push) cnt_q <= cnt_q - CTL_QCW'(1);
		end
	end

endmodule

FILE: hdl/ctl_back.sv
// Token back end: takes records from the queue and hands out their tokens
// one per handshake from an output register. Depends on ctl_pkg, ctl_token_if.
module ctl_back import ctl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  rec_t        head,
	input  q_stat_t     q_stat,
	output logic        pop,
	ctl_token_if.source tokens
);

	rec_t cur_q;
	logic cur_v_q;
	logic idx_q;
	logic last;
	logic fire;

	assign last = !cur_q.two || idx_q;
	assign fire = tokens.valid && tokens.ready;
	assign pop = !q_stat.empty && (!cur_v_q || (fire && last));

	assign tokens.valid = cur_v_q;
	assign tokens.token_kind = idx_q ? cur_q.kind1 : cur_q.kind0;
	assign tokens.token_value = idx_q ? cur_q.value1 : cur_q.value0;
	assign tokens.last_of_run = last;

	always_ff @(posedge clk) begin
		if (pop) cur_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_v_q <= 1'b0;
			idx_q <= 1'b0;
		end else if (pop) begin
			cur_v_q <= 1'b1;
			idx_q <= 1'b0;
		end else if (fire) begin
			if (last) begin
				cur_v_q <= 1'b0;
				idx_q <= 1'b0;
			end else begin
				idx_q <= 1'b1;
			end
		end
	end

endmodule

FILE: tb/sv/tb_config_text_lexer.sv
// Self-checking testbench of config_text_lexer: directed and random byte streams in, token stream checked.
// A built-in token predictor tracks the lexer state per accepted byte and queues expected tokens.
// Depends on ctl_pkg, ctl_byte_if, ctl_token_if and config_text_lexer.
module tb_config_text_lexer;
	import ctl_pkg::*;

	localparam int MAX_ATOM = 64;
	localparam int VALUE_BITS = 64;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 12;
	localparam int RANDOM_ITEMS = 550;
	localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

	typedef enum logic [3:0] {
		LX_IDLE, LX_COMMENT, LX_ZERO, LX_DEC, LX_OCT, LX_HEX,
		LX_ATOM, LX_STRING, LX_ESC, LX_ESC_HEX, LX_ESC_OCT
	} lex_mode_t;

	typedef struct {
		logic [7:0] text_byte;
		logic       eoi;
	} text_item_t;

	typedef struct {
		kind_t       kind;
		logic [63:0] value;
		logic        last;
	} token_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ctl_byte_if text_ch();
	ctl_token_if tok_ch();

	config_text_lexer #(.MAX_ATOM(MAX_ATOM), .VALUE_BITS(VALUE_BITS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_ch),
		.tokens(tok_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	text_item_t text_items[$];
	token_rec_t tokens_due[$];
	int items_total = 0;
	int items_taken = 0;
	int err_count = 0;
	int cycle_count = 0;

	lex_mode_t   lx_mode = LX_IDLE;
	logic        lx_single = 1'b0;
	logic [63:0] lx_num = '0;
	logic [1:0]  lx_digits = '0;
	logic [12:0] lx_atom_len = '0;
	kind_t       run_kind[2];
	logic [63:0] run_val[2];
	int          run_n;

	function automatic bit is_skip(logic [7:0] b);
		return b == 8'h00 || b == " " || b == "\t" || b == 8'h0D || b == 8'h0B || b == 8'h0C;
	endfunction

	function automatic bit is_dec(logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic bit is_oct(logic [7:0] b);
		return b >= "0" && b <= "7";
	endfunction

	function automatic bit ends_atom(logic [7:0] b);
		return is_skip(b) || b == "\n" || b == "." || b == "(" || b == ")" || b == ";" || b == ",";
	endfunction

	function automatic int hex_digit(logic [7:0] b);
		if (is_dec(b))
			return int'(b) - int'("0");
		if (b >= "a" && b <= "f")
			return int'(b) - int'("a") + 10;
		if (b >= "A" && b <= "F")
			return int'(b) - int'("A") + 10;
		return -1;
	endfunction

	function automatic int escape_char(logic [7:0] b);
		case (b)
			"'", "\"", "?", "\\": return int'(b);
			"a": return 7;
			"b": return 8;
			"f": return 12;
			"n": return 10;
			"r": return 13;
			"t": return 9;
			"v": return 11;
			default: return -1;
		endcase
	endfunction

	function automatic void emit(kind_t k, logic [63:0] v);
		if (run_n < 2) begin
			run_kind[run_n] = k;
			run_val[run_n] = v;
			run_n++;
		end
	endfunction

	function automatic void go_idle();
		lx_mode = LX_IDLE;
		lx_num = '0;
		lx_digits = '0;
	endfunction

	function automatic void lex_reset();
		go_idle();
		lx_single = 1'b0;
		lx_atom_len = '0;
	endfunction

	function automatic void lex_idle(logic [7:0] b);
		if (is_skip(b))
			return;
		case (b)
			"\n": emit(KIND_NEWLINE, '0);
			"#": lx_mode = LX_COMMENT;
			"(": emit(KIND_OPEN, '0);
			")": emit(KIND_CLOSE, '0);
			",": emit(KIND_COMMA, '0);
			";": emit(KIND_SEMI, '0);
			".": emit(KIND_ERROR, '0);
			"0": begin
				lx_mode = LX_ZERO;
				lx_num = '0;
			end
			"'", "\"": begin
				lx_mode = LX_STRING;
				lx_single = (b == "'");
			end
			default: begin
				if (is_dec(b)) begin
					lx_mode = LX_DEC;
					lx_num = 64'(b - "0") & VALUE_MASK;
				end else begin
					lx_mode = LX_ATOM;
					lx_atom_len = 13'd1;
					emit(KIND_ATOM_BYTE, 64'(b));
				end
			end
		endcase
	endfunction

	function automatic void lex_string(logic [7:0] b);
		logic [7:0] q;
		q = lx_single ? "'" : "\"";
		if (b == "\\") begin
			lx_mode = LX_ESC;
		end else if (b == q) begin
			emit(KIND_STR_END, '0);
			go_idle();
		end else begin
			emit(KIND_STR_BYTE, 64'(b));
		end
	endfunction

	function automatic void end_number(logic [7:0] b);
		emit(KIND_INTEGER, lx_num);
		go_idle();
		lex_idle(b);
	endfunction

	function automatic void accumulate(logic [63:0] base, logic [63:0] digit);
		lx_num = (lx_num * base + digit) & VALUE_MASK;
	endfunction

	function automatic void close_escape(logic [7:0] b, bit reprocess);
		emit(KIND_STR_BYTE, lx_num & 64'hFF);
		lx_mode = LX_STRING;
		lx_num = '0;
		lx_digits = '0;
		if (reprocess)
			lex_string(b);
	endfunction

	function automatic void tokenize_item(logic [7:0] b, logic eoi);
		token_rec_t rec;
		int d;
		run_n = 0;
		if (eoi) begin
			case (lx_mode)
				LX_ZERO, LX_DEC, LX_OCT, LX_HEX: emit(KIND_INTEGER, lx_num);
				LX_ATOM: emit(KIND_ATOM_END, '0);
				LX_STRING, LX_ESC, LX_ESC_HEX, LX_ESC_OCT: emit(KIND_ERROR, '0);
				default: ;
			endcase
			lex_reset();
		end else begin
			case (lx_mode)
				LX_COMMENT: if (b == "\n") go_idle();
				LX_ZERO: begin
					if (b == "x" || b == "X") begin
						lx_mode = LX_HEX;
						lx_num = '0;
					end else if (is_oct(b)) begin
						lx_mode = LX_OCT;
						lx_num = 64'(b - "0");
					end else begin
						end_number(b);
					end
				end
				LX_DEC: if (is_dec(b)) accumulate(10, 64'(b - "0")); else end_number(b);
				LX_OCT: if (is_oct(b)) accumulate(8, 64'(b - "0")); else end_number(b);
				LX_HEX: begin
					d = hex_digit(b);
					if (d >= 0) accumulate(16, 64'(d)); else end_number(b);
				end
				LX_ATOM: begin
					if (!ends_atom(b)) begin
						if (lx_atom_len < MAX_ATOM) begin
							emit(KIND_ATOM_BYTE, 64'(b));
							lx_atom_len++;
						end
					end else begin
						emit(KIND_ATOM_END, '0);
						lx_atom_len = '0;
						go_idle();
						lex_idle(b);
					end
				end
				LX_STRING: lex_string(b);
				LX_ESC: begin
					d = escape_char(b);
					if (b == "x" || b == "X") begin
						lx_mode = LX_ESC_HEX;
						lx_num = '0;
						lx_digits = '0;
					end else if (is_oct(b)) begin
						lx_mode = LX_ESC_OCT;
						lx_num = 64'(b - "0");
						lx_digits = 2'd1;
					end else if (d >= 0) begin
						emit(KIND_STR_BYTE, 64'(d));
						lx_mode = LX_STRING;
					end else begin
						emit(KIND_ERROR, '0);
						go_idle();
					end
				end
				LX_ESC_HEX: begin
					d = hex_digit(b);
					if (d >= 0) begin
						lx_num = (lx_num * 16 + 64'(d)) & 64'hFF;
						lx_digits++;
						if (lx_digits >= 2)
							close_escape(b, 1'b0);
					end else if (lx_digits == 0) begin
						emit(KIND_ERROR, '0);
						go_idle();
						lex_idle(b);
					end else begin
						close_escape(b, 1'b1);
					end
				end
				LX_ESC_OCT: begin
					if (is_oct(b)) begin
						lx_num = (lx_num * 8 + 64'(b - "0")) & 64'h1FF;
						lx_digits++;
						if (lx_digits >= 3)
							close_escape(b, 1'b0);
					end else begin
						close_escape(b, 1'b1);
					end
				end
				default: begin
					go_idle();
					lex_idle(b);
				end
			endcase
		end
		for (int i = 0; i < run_n; i++) begin
			rec.kind = run_kind[i];
			rec.value = run_val[i];
			rec.last = (i == run_n - 1);
			tokens_due.push_back(rec);
		end
	endfunction

	function automatic void add_byte(logic [7:0] b);
		text_item_t it;
		it.text_byte = b;
		it.eoi = 1'b0;
		text_items.push_back(it);
	endfunction

	function automatic void add_eoi();
		text_item_t it;
		it.text_byte = 8'($urandom_range(255));
		it.eoi = 1'b1;
		text_items.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_byte(s[i]);
	endfunction

	function automatic logic [7:0] atom_char(bit first);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (ends_atom(b) || (first && (is_dec(b) || b == "'" || b == "\"" || b == "#")));
		return b;
	endfunction

	function automatic void add_string(bit broken);
		string hexset;
		string named;
		logic [7:0] q;
		logic [7:0] b;
		int n;
		hexset = "0123456789abcdefABCDEF";
		named = "'\"?\\abfnrtv";
		q = $urandom_range(1) ? "'" : "\"";
		n = $urandom_range(0, 10);
		add_byte(q);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: begin
					do
						b = 8'($urandom_range(255));
					while (b == "\\" || b == q);
					add_byte(b);
				end
				6, 7: begin
					add_byte("\\");
					add_byte(named[$urandom_range(named.len() - 1)]);
				end
				8: begin
					add_byte("\\");
					add_byte($urandom_range(1) ? "x" : "X");
					repeat ($urandom_range(1, 2))
						add_byte(hexset[$urandom_range(hexset.len() - 1)]);
				end
				default: begin
					add_byte("\\");
					repeat ($urandom_range(1, 3))
						add_byte(8'("0" + $urandom_range(7)));
				end
			endcase
		end
		if (!broken) begin
			add_byte(q);
		end else begin
			case ($urandom_range(2))
				0: add_eoi();
				1: begin
					add_byte("\\");
					do
						b = 8'($urandom_range(255));
					while (escape_char(b) >= 0 || is_oct(b) || b == "x" || b == "X");
					add_byte(b);
				end
				default: begin
					add_byte("\\");
					add_byte("x");
					add_byte($urandom_range(1) ? "g" : " ");
				end
			endcase
		end
	endfunction

	function automatic void add_construct();
		string hexset;
		string skipset;
		string puncset;
		logic [7:0] b;
		int n;
		hexset = "0123456789abcdefABCDEF";
		skipset = " \t";
		puncset = "(),;.\n";
		case ($urandom_range(99)) inside
			[0:9]: begin
				case ($urandom_range(5))
					0: add_byte(8'h00);
					1: add_byte(8'h0B);
					2: add_byte(8'h0C);
					3: add_byte(8'h0D);
					default: add_byte(skipset[$urandom_range(1)]);
				endcase
			end
			[10:19]: add_byte(puncset[$urandom_range(5)]);
			[20:24]: begin
				add_byte("#");
				repeat ($urandom_range(0, 6)) begin
					do
						b = 8'($urandom_range(255));
					while (b == "\n");
					add_byte(b);
				end
				add_byte("\n");
			end
			[25:34]: begin
				add_byte(8'("1" + $urandom_range(8)));
				n = ($urandom_range(4) == 0) ? $urandom_range(18, 24) : $urandom_range(0, 5);
				repeat (n)
					add_byte(8'("0" + $urandom_range(9)));
			end
			[35:41]: begin
				add_byte("0");
				n = ($urandom_range(4) == 0) ? $urandom_range(20, 25) : $urandom_range(0, 4);
				repeat (n)
					add_byte(8'("0" + $urandom_range(7)));
			end
			[42:49]: begin
				add_byte("0");
				add_byte($urandom_range(1) ? "x" : "X");
				n = ($urandom_range(4) == 0) ? $urandom_range(15, 18) : $urandom_range(0, 5);
				repeat (n)
					add_byte(hexset[$urandom_range(hexset.len() - 1)]);
			end
			[50:64]: begin
				n = ($urandom_range(9) == 0) ? $urandom_range(60, 72) : $urandom_range(1, 8);
				add_byte(atom_char(1'b1));
				repeat (n - 1)
					add_byte(atom_char(1'b0));
			end
			[65:84]: add_string(1'b0);
			[85:89]: add_eoi();
			[90:94]: add_byte(8'($urandom_range(255)));
			default: add_string(1'b1);
		endcase
		if ($urandom_range(1))
			add_byte(" ");
	endfunction

	int gap_left = 0;
	int burst_left = 1;
	text_item_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_ch.valid <= 1'b0;
			text_ch.in_byte <= '0;
			text_ch.end_of_input <= 1'b0;
		end else begin
			if (text_ch.valid && text_ch.ready) begin
				tokenize_item(text_ch.in_byte, text_ch.end_of_input);
				items_taken++;
			end
			if (!text_ch.valid || text_ch.ready) begin
				if (gap_left > 0 || text_items.size() == 0) begin
					if (gap_left > 0)
						gap_left--;
					text_ch.valid <= 1'b0;
				end else begin
					cur = text_items.pop_front();
					text_ch.valid <= 1'b1;
					text_ch.in_byte <= cur.text_byte;
					text_ch.end_of_input <= cur.eoi;
					burst_left--;
					if (burst_left <= 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
		end
	end

	int stall_pct = 0;
	int stall_phase = 0;
	token_rec_t want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_ch.ready <= 1'b0;
		end else begin
			if (tok_ch.valid && tok_ch.ready) begin
				if (tokens_due.size() == 0) begin
					$error("unexpected token: token_kind %0d token_value %0h",
						tok_ch.token_kind, tok_ch.token_value);
					err_count++;
				end else begin
					want = tokens_due.pop_front();
					if (tok_ch.token_kind !== want.kind) begin
						$error("token_kind expected %0d actual %0d", want.kind, tok_ch.token_kind);
						err_count++;
					end
					if (tok_ch.token_value !== want.value) begin
						$error("token_value expected %0h actual %0h", want.value,
							tok_ch.token_value);
						err_count++;
					end
					if (tok_ch.last_of_run !== want.last) begin
						$error("last_of_run expected %0b actual %0b", want.last,
							tok_ch.last_of_run);
						err_count++;
					end
				end
			end
			if (stall_phase == 0) begin
				stall_phase = $urandom_range(16, 96);
				case ($urandom_range(2))
					0: stall_pct = 0;
					1: stall_pct = 40;
					default: stall_pct = 80;
				endcase
			end
			stall_phase--;
			tok_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		int directed_n;
		text_ch.valid = 1'b0;
		text_ch.in_byte = '0;
		text_ch.end_of_input = 1'b0;
		tok_ch.ready = 1'b0;
		lex_reset();

		add_text("(),;.\n \t");
		add_byte(8'h0D);
		add_byte(8'h0B);
		add_byte(8'h0C);
		add_byte(8'h00);
		add_text("09 0x;0XFFFFFFFFFFFFFFFFF,18446744073709551616 0777)");
		add_text("'a\\t\\x4g\\101\\7\"\\?' \"\\q\"\\xg ");
		add_byte(8'hFF);
		add_text("#c;\n");
		add_eoi();
		add_text("'ab");
		add_eoi();
		add_text("12");
		add_eoi();
		directed_n = text_items.size();
		while (text_items.size() < directed_n + RANDOM_ITEMS)
			add_construct();
		add_eoi();
		items_total = text_items.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (items_taken < items_total || tokens_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && tokens_due.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
